// ===== sv/bpa_pkg.sv =====
// Shared types, constants and microprogram of the buddy page allocator.
// Used by bpa_seq, bpa_dp and buddy_page_allocator; depends on nothing else.
`default_nettype none

package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF = 256;
  localparam int unsigned FIELD_W       = 9;
  localparam int unsigned OFFSET_W      = 8;
  // Requests are not capped by the tree: they may round up past the root
  localparam int unsigned REQ_CAP       = 9;
  localparam logic [FIELD_W-1:0] MANAGED_RESET = 9'd256;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // Step addresses of the microprogram
  typedef logic [3:0] step_t;
  localparam step_t P_IDLE = 4'd0;
  localparam step_t P_ROOT = 4'd1;
  localparam step_t P_DESC = 4'd2;
  localparam step_t P_PICK = 4'd3;
  localparam step_t P_MARK = 4'd4;
  localparam step_t P_UPRD = 4'd5;
  localparam step_t P_UPWR = 4'd6;
  localparam step_t P_DONE = 4'd7;
  localparam step_t P_FAIL = 4'd8;
  localparam step_t P_CLR  = 4'd9;

  typedef enum logic [1:0] {RD_NONE, RD_ROOT, RD_LEFT, RD_SIB} rd_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_ZERO, WR_MAX, WR_CLR} wr_op_t;
  typedef enum logic [2:0] {
    C_ALWAYS, C_ACCEPT, C_ROOT_LT, C_SIZE_EQ, C_IDX_ZERO, C_OUT_FREE, C_CLR_LAST
  } cond_t;

  typedef struct packed {
    rd_op_t rd;
    wr_op_t wr;
    logic   init;     // idx to root, size to total, offset to zero
    logic   ld_req;   // latch request size code (on taken jump)
    logic   pick;     // step one level down
    logic   up;       // step to parent
    logic   out_ok;   // load success result (on taken jump)
    logic   out_fail; // load failure result (on taken jump)
    cond_t  cond;
    step_t  jt;
    step_t  jf;
  } ctl_t;

  typedef struct packed {
    ctl_t ctl;
    logic take;
  } seq_out_t;

  typedef struct packed {
    logic root_lt;
    logic size_eq;
    logic idx_zero;
    logic clr_last;
    logic out_free;
  } dp_flags_t;

  // Size code of a page count: 0 means nothing free, k+1 means 2**k pages.
  // Zero counts as one page; the exponent saturates at cap.
  function automatic int unsigned pages_code(logic [FIELD_W-1:0] m, int unsigned cap);
    int unsigned e;
    e = 0;
    for (int k = 0; k < FIELD_W; k++) begin
      if ((32'd1 << k) < {{(32-FIELD_W){1'b0}}, m}) begin
        e = e + 1;
      end
    end
    if (e > cap) begin
      e = cap;
    end
    return e + 1;
  endfunction

  // Control store
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = '0;
    case (s)
      P_IDLE: begin
        c.rd = RD_ROOT; c.init = 1'b1; c.ld_req = 1'b1;
        c.cond = C_ACCEPT; c.jt = P_ROOT; c.jf = P_IDLE;
      end
      P_ROOT: begin
        c.cond = C_ROOT_LT; c.jt = P_FAIL; c.jf = P_DESC;
      end
      P_DESC: begin
        c.rd = RD_LEFT;
        c.cond = C_SIZE_EQ; c.jt = P_MARK; c.jf = P_PICK;
      end
      P_PICK: begin
        c.pick = 1'b1;
        c.cond = C_ALWAYS; c.jt = P_DESC; c.jf = P_DESC;
      end
      P_MARK: begin
        c.wr = WR_ZERO;
        c.cond = C_IDX_ZERO; c.jt = P_DONE; c.jf = P_UPRD;
      end
      P_UPRD: begin
        c.rd = RD_SIB; c.up = 1'b1;
        c.cond = C_ALWAYS; c.jt = P_UPWR; c.jf = P_UPWR;
      end
      P_UPWR: begin
        c.wr = WR_MAX;
        c.cond = C_IDX_ZERO; c.jt = P_DONE; c.jf = P_UPRD;
      end
      P_DONE: begin
        c.out_ok = 1'b1;
        c.cond = C_OUT_FREE; c.jt = P_IDLE; c.jf = P_DONE;
      end
      P_FAIL: begin
        c.out_fail = 1'b1;
        c.cond = C_OUT_FREE; c.jt = P_IDLE; c.jf = P_FAIL;
      end
      P_CLR: begin
        c.wr = WR_CLR;
        c.cond = C_CLR_LAST; c.jt = P_IDLE; c.jf = P_CLR;
      end
      default: begin
        c.cond = C_ALWAYS; c.jt = P_IDLE; c.jf = P_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/buddy_page_allocator.sv =====
// Top level of the binary buddy page allocator: sequencer plus datapath.
// Depends on bpa_pkg, bpa_seq, bpa_dp and bpa_ram.
//
//   channel  handshake            payload
//   req      req_valid/req_ready  request_pages[8:0]
//   rsp      rsp_valid/rsp_ready  status, page_offset[7:0]
//   cfg      cfg_we               managed_pages[8:0]
//
// A request goes from accept to result through the root check, then per tree level
// going down a left child read and a choice, a mark of the node it reaches, and per
// level back up a sibling read and a max write, on the read and write ports of the
// one tree RAM. A request that does not fit returns straight from the root check.
// Reset and every cfg beat rebuild the whole tree with req_ready low. A finished
// result waits in the output register; the next beat is taken meanwhile.
`default_nettype none

module buddy_page_allocator #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bpa_pkg::FIELD_W-1:0] managed_pages,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [bpa_pkg::FIELD_W-1:0] request_pages,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic                             status,
  output logic [bpa_pkg::OFFSET_W-1:0]     page_offset
);

  bpa_pkg::seq_out_t  seq;
  bpa_pkg::dp_flags_t flags;
  bpa_pkg::step_t     step;

  bpa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .flags     (flags),
    .seq       (seq),
    .step      (step)
  );

  bpa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .managed_pages (managed_pages),
    .request_pages (request_pages),
    .seq           (seq),
    .flags         (flags),
    .rsp_ready     (rsp_ready),
    .rsp_valid     (rsp_valid),
    .status        (status),
    .page_offset   (page_offset)
  );

`ifndef ASSERT_OFF
  a_rebuild_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req_ready)
    else $error("request taken during tree rebuild");

  a_accept_root: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> step == bpa_pkg::P_ROOT)
    else $error("accepted beat did not start the root check");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(step) == bpa_pkg::P_DONE || $past(step) == bpa_pkg::P_FAIL)
    else $error("result raised outside a result step");

  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bpa_pkg::ST_FAIL |-> page_offset == '0)
    else $error("failed request with non-zero offset");
`endif

endmodule

`default_nettype wire

// ===== sv/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/bpa_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on bpa_pkg.
`default_nettype none

module bpa_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire bpa_pkg::dp_flags_t  flags,
  output bpa_pkg::seq_out_t        seq,
  output bpa_pkg::step_t           step
);

  bpa_pkg::ctl_t ctl;
  logic          cond_true;

  assign ctl       = bpa_pkg::ucode(step);
  // Hold off a beat that coincides with a rebuild request
  assign req_ready = (step == bpa_pkg::P_IDLE) && !cfg_we;

  always_comb begin
    case (ctl.cond)
      bpa_pkg::C_ALWAYS:   cond_true = 1'b1;
      bpa_pkg::C_ACCEPT:   cond_true = req_valid && req_ready;
      bpa_pkg::C_ROOT_LT:  cond_true = flags.root_lt;
      bpa_pkg::C_SIZE_EQ:  cond_true = flags.size_eq;
      bpa_pkg::C_IDX_ZERO: cond_true = flags.idx_zero;
      bpa_pkg::C_OUT_FREE: cond_true = flags.out_free;
      bpa_pkg::C_CLR_LAST: cond_true = flags.clr_last;
      default:             cond_true = 1'b0;
    endcase
  end

  assign seq.ctl  = ctl;
  assign seq.take = cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bpa_pkg::P_CLR;
    end else if (cfg_we) begin
      step <= bpa_pkg::P_CLR;
    end else begin
      step <= cond_true ? ctl.jt : ctl.jf;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bpa_dp.sv =====
// Datapath: tree memory, descent and update registers, rebuild counters, result register.
// Depends on bpa_pkg and bpa_ram.
`default_nettype none

module bpa_dp #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bpa_pkg::FIELD_W-1:0]     managed_pages,
  input  wire logic [bpa_pkg::FIELD_W-1:0]     request_pages,
  input  wire bpa_pkg::seq_out_t               seq,
  output bpa_pkg::dp_flags_t                   flags,
  input  wire logic                            rsp_ready,
  output logic                                 rsp_valid,
  output logic                                 status,
  output logic [bpa_pkg::OFFSET_W-1:0]         page_offset
);

  localparam int unsigned LOG   = $clog2(MAX_PAGES);
  localparam int unsigned CW    = $clog2((LOG + 2 > 11) ? LOG + 2 : 11);
  localparam int unsigned AW    = LOG + 1;
  localparam int unsigned OW    = LOG;
  localparam int unsigned DEPTH = 2 * MAX_PAGES;

  logic [CW-1:0] tcode;     // size code of the managed total
  logic [CW-1:0] rc;        // size code of the request
  logic [AW-1:0] idx;
  logic [CW-1:0] sc;        // size code of the node at idx
  logic [OW-1:0] off;
  logic [CW-1:0] cval;      // value last written on the way up
  logic [AW-1:0] cnt;
  logic [CW-1:0] clr_code;
  logic [AW-1:0] lvl_mark;  // first node of the next tree level

  logic [AW-1:0] cnt_next;
  logic [AW-1:0] left;
  logic [AW-1:0] right;
  logic [AW-1:0] sib;
  logic [AW-1:0] parent;
  logic [CW-1:0] rdata;
  logic [CW-1:0] upmax;
  logic [OW-1:0] addend;
  logic          go_left;
  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic          load_ok;
  logic          load_fail;

  assign cnt_next  = cnt + AW'(1);
  assign left      = {idx[AW-2:0], 1'b1};
  assign right     = left + AW'(1);
  assign sib       = idx[0] ? idx + AW'(1) : idx - AW'(1);
  assign parent    = AW'((idx - AW'(1)) >> 1);
  assign upmax     = (cval > rdata) ? cval : rdata;
  assign go_left   = (rdata >= rc);
  assign addend    = OW'(1) << (sc - CW'(2));
  assign load_ok   = seq.ctl.out_ok && seq.take;
  assign load_fail = seq.ctl.out_fail && seq.take;

  assign flags.root_lt  = (rdata < rc);
  assign flags.size_eq  = (sc == rc);
  assign flags.idx_zero = (idx == '0);
  assign flags.clr_last = (cnt == '1);
  assign flags.out_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (seq.ctl.rd)
      bpa_pkg::RD_LEFT: raddr = left;
      bpa_pkg::RD_SIB:  raddr = sib;
      default:          raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx;
    case (seq.ctl.wr)
      bpa_pkg::WR_ZERO: wdata = '0;
      bpa_pkg::WR_MAX:  wdata = upmax;
      bpa_pkg::WR_CLR: begin
        waddr = cnt;
        wdata = clr_code;
      end
      default: begin
        we    = 1'b0;
        wdata = '0;
      end
    endcase
  end

  bpa_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control and configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      tcode     <= CW'(bpa_pkg::pages_code(bpa_pkg::MANAGED_RESET, LOG));
      clr_code  <= CW'(bpa_pkg::pages_code(bpa_pkg::MANAGED_RESET, LOG));
      cnt       <= '0;
      lvl_mark  <= AW'(1);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tcode    <= CW'(bpa_pkg::pages_code(managed_pages, LOG));
        clr_code <= CW'(bpa_pkg::pages_code(managed_pages, LOG));
        cnt      <= '0;
        lvl_mark <= AW'(1);
      end else if (seq.ctl.wr == bpa_pkg::WR_CLR) begin
        cnt <= cnt_next;
        // Each new level holds half the size; below the leaves it holds zero
        if (cnt_next == lvl_mark) begin
          clr_code <= (clr_code == '0) ? '0 : clr_code - CW'(1);
          lvl_mark <= {lvl_mark[AW-2:0], 1'b1};
        end
      end
      if (load_ok || load_fail) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (seq.ctl.init) begin
      idx <= '0;
      sc  <= tcode;
      off <= '0;
    end
    if (seq.ctl.ld_req && seq.take) begin
      rc <= CW'(bpa_pkg::pages_code(request_pages, bpa_pkg::REQ_CAP));
    end
    if (seq.ctl.pick) begin
      idx <= go_left ? left : right;
      sc  <= sc - CW'(1);
      if (!go_left) begin
        off <= off + addend;
      end
    end
    if (seq.ctl.up) begin
      idx <= parent;
    end
    if (seq.ctl.wr == bpa_pkg::WR_ZERO) begin
      cval <= '0;
    end else if (seq.ctl.wr == bpa_pkg::WR_MAX) begin
      cval <= upmax;
    end
    if (load_ok) begin
      status      <= bpa_pkg::ST_OK;
      page_offset <= bpa_pkg::OFFSET_W'(off);
    end else if (load_fail) begin
      status      <= bpa_pkg::ST_FAIL;
      page_offset <= '0;
    end
  end

endmodule

`default_nettype wire
